// ----- rtl/esc_pkg.sv -----
// Shared types, codes and constants for the elevator scan controller.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package esc_pkg;

	// Car modes, one-hot inside the controller.
	typedef enum logic [5:0] {
		MODE_IDLE   = 6'b000001,
		MODE_UP     = 6'b000010,
		MODE_DOWN   = 6'b000100,
		MODE_DOOR   = 6'b001000,
		MODE_ALARM  = 6'b010000,
		MODE_MANUAL = 6'b100000
	} mode_t;

	// Mode codes as they appear in a result word.
	localparam logic [2:0] MODE_CODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_CODE_UP     = 3'd1;
	localparam logic [2:0] MODE_CODE_DOWN   = 3'd2;
	localparam logic [2:0] MODE_CODE_DOOR   = 3'd3;
	localparam logic [2:0] MODE_CODE_ALARM  = 3'd4;
	localparam logic [2:0] MODE_CODE_MANUAL = 3'd5;

	// Travel direction codes.
	localparam logic [1:0] MOVE_NONE = 2'd0;
	localparam logic [1:0] MOVE_UP   = 2'd1;
	localparam logic [1:0] MOVE_DOWN = 2'd2;

	// Buzzer counts.
	localparam logic [1:0] BEEP_NONE  = 2'd0;
	localparam logic [1:0] BEEP_ONE   = 2'd1;
	localparam logic [1:0] BEEP_ALARM = 2'd3;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_STEPS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_OPEN_STEPS = 2'd1;
	localparam logic [15:0] TRAVEL_STEPS_RESET    = 16'd200;
	localparam logic [15:0] DOOR_OPEN_STEPS_RESET = 16'd3000;

	// Number of floor buttons carried by an input word.
	localparam int unsigned PRESS_W = 5;

	typedef struct packed {
		logic [PRESS_W-1:0] floor_presses;
		logic               stop_press;
		logic               open_press;
		logic               close_press;
	} esc_item_t;

	typedef struct packed {
		logic [2:0]         mode;
		logic [2:0]         current_floor;
		logic [2:0]         target_floor;
		logic [1:0]         travel_dir;
		logic [PRESS_W-1:0] pending_floors;
		logic               motor_up;
		logic               motor_down;
		logic               door_open;
		logic [1:0]         beeps;
		logic [31:0]        ride_count;
	} esc_result_t;

	// Saturating buzzer accumulation.
	function automatic logic [1:0] beep_add(logic [1:0] acc, logic [1:0] n);
		logic [2:0] sum;
		sum = {1'b0, acc} + {1'b0, n};
		return (sum > 3'd3) ? 2'd3 : sum[1:0];
	endfunction

	function automatic logic [2:0] mode_code(mode_t m);
		logic [2:0] code;
		unique case (m)
			MODE_IDLE:   code = MODE_CODE_IDLE;
			MODE_UP:     code = MODE_CODE_UP;
			MODE_DOWN:   code = MODE_CODE_DOWN;
			MODE_DOOR:   code = MODE_CODE_DOOR;
			MODE_ALARM:  code = MODE_CODE_ALARM;
			MODE_MANUAL: code = MODE_CODE_MANUAL;
			default:     code = MODE_CODE_IDLE;
		endcase
		return code;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/esc_scan.sv -----
// SCAN target chooser: nearest pending floor in the travel direction, else the other way.
// Depends on esc_pkg for direction codes and the button count.
`timescale 1ns / 1ps
`default_nettype none

module esc_scan
	import esc_pkg::*;
#(
	parameter int unsigned FLOOR_W = 3
) (
	input  wire logic [1:0]         dir,
	input  wire logic [FLOOR_W-1:0] floor,
	input  wire logic [PRESS_W-1:0] mask,
	output      logic [FLOOR_W-1:0] target
);

	logic [FLOOR_W-1:0] tgt_up;
	logic [FLOOR_W-1:0] tgt_dn;

	// Lowest pending floor above, highest pending floor below.
	always_comb begin
		tgt_up = '0;
		tgt_dn = '0;
		for (int i = PRESS_W - 1; i >= 0; i--) begin
			if (mask[i] && (8'(i + 1) > 8'(floor))) begin
				tgt_up = FLOOR_W'(i + 1);
			end
		end
		for (int i = 0; i < PRESS_W; i++) begin
			if (mask[i] && (8'(i + 1) < 8'(floor))) begin
				tgt_dn = FLOOR_W'(i + 1);
			end
		end
	end

	always_comb begin
		if (dir == MOVE_DOWN) begin
			target = (tgt_dn != '0) ? tgt_dn : tgt_up;
		end else begin
			target = (tgt_up != '0) ? tgt_up : tgt_dn;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/esc_core.sv -----
// Car state registers and the one-step next-state logic of the elevator controller.
// Depends on esc_pkg and esc_scan.
`timescale 1ns / 1ps
`default_nettype none

module esc_core
	import esc_pkg::*;
#(
	parameter int unsigned NUM_FLOORS = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step_en,
	input  wire esc_item_t   item,
	input  wire logic [15:0] travel_steps,
	input  wire logic [15:0] door_open_steps,
	output      esc_result_t result
);

	localparam int unsigned FLOOR_W = $clog2(NUM_FLOORS + 1);
	localparam logic [FLOOR_W-1:0] FLOOR_ONE = FLOOR_W'(1);
	localparam logic [FLOOR_W-1:0] FLOOR_TOP = FLOOR_W'(NUM_FLOORS);

	// One-hot button position of a floor; floors above the buttons give zero.
	function automatic logic [PRESS_W-1:0] floor_bit(logic [FLOOR_W-1:0] f);
		logic [PRESS_W-1:0] oh;
		for (int i = 0; i < PRESS_W; i++) begin
			oh[i] = (8'(f) == 8'(i + 1));
		end
		return oh;
	endfunction

	mode_t              mode_q;
	logic [1:0]         dir_q;
	logic [FLOOR_W-1:0] floor_q;
	logic [FLOOR_W-1:0] target_q;
	logic [PRESS_W-1:0] pending_q;
	logic [15:0]        door_cnt_q;
	logic               door_exp_q;
	logic [15:0]        up_cnt_q;
	logic [15:0]        down_cnt_q;
	logic [31:0]        rides_q;

	// Values after the button presses, before the mode step.
	mode_t              mode_a;
	logic [1:0]         dir_a;
	logic [PRESS_W-1:0] pending_a;
	logic [15:0]        door_cnt_a;
	logic               door_exp_a;
	logic [1:0]         beep_a;
	logic [PRESS_W-1:0] floor_oh;

	// Values after the whole step.
	mode_t              mode_n;
	logic [1:0]         dir_n;
	logic [FLOOR_W-1:0] floor_n;
	logic [FLOOR_W-1:0] target_n;
	logic [PRESS_W-1:0] pending_n;
	logic [15:0]        door_cnt_n;
	logic               door_exp_n;
	logic [15:0]        up_cnt_n;
	logic [15:0]        down_cnt_n;
	logic [31:0]        rides_n;
	logic [1:0]         beep_n;

	logic [FLOOR_W-1:0] floor_arr;
	logic [PRESS_W-1:0] arr_oh;
	logic [PRESS_W-1:0] pending_arr;
	logic [FLOOR_W-1:0] tgt_idle;
	logic [FLOOR_W-1:0] tgt_arr;
	logic [15:0]        up_inc;
	logic [15:0]        down_inc;
	logic [7:0]         floor_ext;
	logic [7:0]         target_ext;

	assign floor_oh = floor_bit(floor_q);

	always_comb begin
		mode_a     = mode_q;
		dir_a      = dir_q;
		pending_a  = pending_q;
		door_cnt_a = door_cnt_q;
		door_exp_a = door_exp_q;
		beep_a     = BEEP_NONE;
		if (mode_q != MODE_ALARM) begin
			for (int i = 0; i < PRESS_W; i++) begin
				if ((i < NUM_FLOORS) && item.floor_presses[i] &&
						!(floor_oh[i] && (mode_q == MODE_DOOR))) begin
					pending_a[i] = 1'b1;
				end
			end
		end
		if (item.stop_press) begin
			if (mode_a != MODE_ALARM) begin
				mode_a = MODE_ALARM;
				beep_a = beep_add(beep_a, BEEP_ALARM);
			end else begin
				mode_a    = MODE_IDLE;
				dir_a     = MOVE_NONE;
				pending_a = '0;
				beep_a    = beep_add(beep_a, BEEP_ONE);
			end
		end
		if (item.open_press && (mode_a == MODE_IDLE)) begin
			door_cnt_a = door_open_steps;
			door_exp_a = 1'b0;
			beep_a     = beep_add(beep_a, BEEP_ONE);
			mode_a     = MODE_MANUAL;
		end
		if (item.close_press && ((mode_a == MODE_DOOR) || (mode_a == MODE_MANUAL))) begin
			door_cnt_a = '0;
			mode_a     = MODE_IDLE;
		end
	end

	// The floor the car reaches if it completes a floor of travel this step.
	assign floor_arr   = (mode_a == MODE_UP) ? floor_q + FLOOR_ONE : floor_q - FLOOR_ONE;
	assign arr_oh      = floor_bit(floor_arr);
	assign pending_arr = pending_a & ~arr_oh;
	assign up_inc      = up_cnt_q + 16'd1;
	assign down_inc    = down_cnt_q + 16'd1;

	esc_scan #(.FLOOR_W(FLOOR_W)) u_scan_idle (
		.dir    (dir_a),
		.floor  (floor_q),
		.mask   (pending_a),
		.target (tgt_idle)
	);

	esc_scan #(.FLOOR_W(FLOOR_W)) u_scan_arrive (
		.dir    (dir_a),
		.floor  (floor_arr),
		.mask   (pending_arr),
		.target (tgt_arr)
	);

	always_comb begin
		mode_n     = mode_a;
		dir_n      = dir_a;
		floor_n    = floor_q;
		target_n   = target_q;
		pending_n  = pending_a;
		door_cnt_n = door_cnt_a;
		door_exp_n = door_exp_a;
		up_cnt_n   = up_cnt_q;
		down_cnt_n = down_cnt_q;
		rides_n    = rides_q;
		beep_n     = beep_a;
		unique case (mode_a)
			MODE_IDLE: begin
				if (pending_a != '0) begin
					if ((pending_a & floor_oh) != '0) begin
						// A request at the car's own floor is served in place.
						target_n   = floor_q;
						pending_n  = pending_a & ~floor_oh;
						door_cnt_n = door_open_steps;
						door_exp_n = 1'b0;
						beep_n     = beep_add(beep_a, BEEP_ONE);
						mode_n     = MODE_DOOR;
					end else begin
						target_n = tgt_idle;
						if (tgt_idle != '0) begin
							if (tgt_idle > floor_q) begin
								dir_n  = MOVE_UP;
								mode_n = MODE_UP;
							end else begin
								dir_n  = MOVE_DOWN;
								mode_n = MODE_DOWN;
							end
							rides_n = rides_q + 32'd1;
						end
					end
				end
			end
			MODE_UP, MODE_DOWN: begin
				if (mode_a == MODE_UP) begin
					up_cnt_n = up_inc;
				end else begin
					down_cnt_n = down_inc;
				end
				if (((mode_a == MODE_UP) ? up_inc : down_inc) >= travel_steps) begin
					if (mode_a == MODE_UP) begin
						up_cnt_n = '0;
					end else begin
						down_cnt_n = '0;
					end
					if ((mode_a == MODE_UP) ? (floor_q < FLOOR_TOP) : (floor_q > FLOOR_ONE))
							begin
						floor_n = floor_arr;
						if ((floor_arr == target_q) || ((pending_a & arr_oh) != '0)) begin
							pending_n  = pending_arr;
							door_cnt_n = door_open_steps;
							door_exp_n = 1'b0;
							beep_n     = beep_add(beep_a, BEEP_ONE);
							mode_n     = MODE_DOOR;
							// A stop on the way picks the next target afresh.
							if (floor_arr != target_q) begin
								target_n = tgt_arr;
							end
						end
					end else begin
						// Running past a limit floor.
						mode_n = MODE_ALARM;
						beep_n = beep_add(beep_a, BEEP_ALARM);
					end
				end
			end
			MODE_DOOR: begin
				if (door_exp_a) begin
					door_exp_n = 1'b0;
					dir_n      = MOVE_NONE;
					mode_n     = MODE_IDLE;
				end
			end
			MODE_ALARM, MODE_MANUAL: begin
			end
			default: begin
			end
		endcase
		if ((mode_n == MODE_DOOR) && (door_cnt_n != '0)) begin
			door_cnt_n = door_cnt_n - 16'd1;
			if (door_cnt_n == '0) begin
				door_exp_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_DOOR;
			dir_q      <= MOVE_NONE;
			floor_q    <= FLOOR_ONE;
			target_q   <= FLOOR_ONE;
			pending_q  <= '0;
			door_cnt_q <= DOOR_OPEN_STEPS_RESET;
			door_exp_q <= 1'b0;
			up_cnt_q   <= '0;
			down_cnt_q <= '0;
			rides_q    <= '0;
		end else if (step_en) begin
			mode_q     <= mode_n;
			dir_q      <= dir_n;
			floor_q    <= floor_n;
			target_q   <= target_n;
			pending_q  <= pending_n;
			door_cnt_q <= door_cnt_n;
			door_exp_q <= door_exp_n;
			up_cnt_q   <= up_cnt_n;
			down_cnt_q <= down_cnt_n;
			rides_q    <= rides_n;
		end
	end

	assign floor_ext  = 8'(floor_n);
	assign target_ext = 8'(target_n);

	always_comb begin
		result.mode           = mode_code(mode_n);
		result.current_floor  = floor_ext[2:0];
		result.target_floor   = target_ext[2:0];
		result.travel_dir     = dir_n;
		result.pending_floors = pending_n;
		result.motor_up       = (mode_n == MODE_UP);
		result.motor_down     = (mode_n == MODE_DOWN);
		result.door_open      = (mode_n == MODE_DOOR) || (mode_n == MODE_MANUAL);
		result.beeps          = beep_n;
		result.ride_count     = rides_n;
	end

endmodule

`default_nettype wire

// ----- rtl/elevator_scan_controller_unit.sv -----
// Elevator scan controller, top level: input word register, step logic, result register.
// An accepted input word is registered, then stepped into the result register.
// Throughput: one input word per cycle unless m_tready stalls the result register.
// Reset (arst_n low, asynchronous): car at floor 1 with door open, no requests,
// travel_steps 200, door_open_steps 3000, both pipeline stages empty.
// Depends on esc_pkg, esc_scan and esc_core.
`timescale 1ns / 1ps
`default_nettype none

module elevator_scan_controller_unit
	import esc_pkg::*;
#(
	parameter int unsigned NUM_FLOORS = 5
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// Input words: one time step of button presses.
	input  wire logic                 s_tvalid,
	output      logic                 s_tready,
	// [4:0] floor_presses, [5] stop_press, [6] open_press, [7] close_press
	input  wire logic [7:0]           s_tdata,

	// Result words: car status after each time step.
	output      logic                 m_tvalid,
	input  wire logic                 m_tready,
	// [2:0] mode, [5:3] current_floor, [8:6] target_floor, [10:9] travel_dir,
	// [15:11] pending_floors, [16] motor_up, [17] motor_down, [18] door_open,
	// [20:19] beeps, [52:21] ride_count, [55:53] zero
	output      logic [55:0]          m_tdata,

	// Configuration writes: index 0 travel_steps, index 1 door_open_steps.
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [15:0]          cfg_data
);

	esc_item_t   item_s1;
	logic        valid_s1;
	esc_result_t result_s2;
	logic        valid_s2;
	esc_result_t result_nxt;
	logic        advance;
	logic [15:0] travel_steps_q;
	logic [15:0] door_open_steps_q;

	// The registered word moves into the result register whenever that register is
	// empty or is being drained this cycle; the car state steps at the same edge.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.floor_presses <= s_tdata[4:0];
			item_s1.stop_press    <= s_tdata[5];
			item_s1.open_press    <= s_tdata[6];
			item_s1.close_press   <= s_tdata[7];
		end
	end

	// Configuration is always accepted; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_steps_q    <= TRAVEL_STEPS_RESET;
			door_open_steps_q <= DOOR_OPEN_STEPS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_TRAVEL_STEPS) begin
				travel_steps_q <= cfg_data;
			end
			if (cfg_index == CFG_DOOR_OPEN_STEPS) begin
				door_open_steps_q <= cfg_data;
			end
		end
	end

	esc_core #(.NUM_FLOORS(NUM_FLOORS)) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (advance),
		.item            (item_s1),
		.travel_steps    (travel_steps_q),
		.door_open_steps (door_open_steps_q),
		.result          (result_nxt)
	);

	// Result register: holds a word until the downstream side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'b000,
		result_s2.ride_count,
		result_s2.beeps,
		result_s2.door_open,
		result_s2.motor_down,
		result_s2.motor_up,
		result_s2.pending_floors,
		result_s2.travel_dir,
		result_s2.target_floor,
		result_s2.current_floor,
		result_s2.mode};

endmodule

`default_nettype wire

// ----- test/elevator_scan_controller_unit_test.sv -----
// Testbench for elevator_scan_controller_unit: directed and random button words against a
// cycle-free model of the car, with random idling on both stream sides.
// Depends on esc_pkg and the RTL under rtl/.
`timescale 1ns / 1ps

module elevator_scan_controller_unit_test;
	import esc_pkg::*;

	localparam int NUM_FLOORS = 5;
	localparam int DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 40;

	// Input word layout: [4:0] floor buttons, [5] stop, [6] open, [7] close.
	localparam logic [7:0] PRESS_MASK = 8'h1F;
	localparam logic [7:0] STOP_WORD  = 8'h20;
	localparam logic [7:0] OPEN_WORD  = 8'h40;
	localparam logic [7:0] CLOSE_WORD = 8'h80;
	localparam logic [7:0] NO_PRESS   = 8'h00;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [55:0]          m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	elevator_scan_controller_unit #(
		.NUM_FLOORS(NUM_FLOORS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Model of the car: configuration copy and state.
	logic [15:0] cfg_travel_steps = TRAVEL_STEPS_RESET;
	logic [15:0] cfg_door_steps = DOOR_OPEN_STEPS_RESET;
	logic [2:0]  car_mode = MODE_CODE_DOOR;
	logic [1:0]  car_dir = MOVE_NONE;
	logic [2:0]  car_floor = 3'd1;
	logic [2:0]  car_target = 3'd1;
	logic [4:0]  pending_req = '0;
	logic [15:0] door_timer = DOOR_OPEN_STEPS_RESET;
	logic        door_timed_out = 1'b0;
	logic [15:0] up_steps = '0;
	logic [15:0] down_steps = '0;
	logic [31:0] ride_total = '0;
	logic [1:0]  beep_sum = BEEP_NONE;

	esc_result_t car_status_due[$];
	int          bad_fields = 0;
	bit          steady_flow = 1'b0;
	int          stall_left = 0;
	int unsigned cycle_count = 0;

	function automatic bit req_at(int f);
		if (f < 1 || f > NUM_FLOORS)
			return 1'b0;
		return pending_req[f-1];
	endfunction

	function automatic void drop_req(int f);
		if (f >= 1 && f <= NUM_FLOORS)
			pending_req[f-1] = 1'b0;
	endfunction

	function automatic logic [2:0] scan_up();
		int f;
		for (f = int'(car_floor) + 1; f <= NUM_FLOORS; f++)
			if (req_at(f))
				return 3'(f);
		return 3'd0;
	endfunction

	function automatic logic [2:0] scan_down();
		int f;
		for (f = int'(car_floor) - 1; f >= 1; f--)
			if (req_at(f))
				return 3'(f);
		return 3'd0;
	endfunction

	// SCAN order: keep going the way the car last went, upward when it has no direction.
	function automatic logic [2:0] pick_target();
		logic [2:0] t;
		if (car_dir == MOVE_DOWN) begin
			t = scan_down();
			if (t == 3'd0)
				t = scan_up();
		end else begin
			t = scan_up();
			if (t == 3'd0)
				t = scan_down();
		end
		return t;
	endfunction

	function automatic void add_beep(logic [1:0] n);
		logic [2:0] sum;
		sum = {1'b0, beep_sum} + {1'b0, n};
		beep_sum = (sum > 3'd3) ? 2'd3 : sum[1:0];
	endfunction

	function automatic void open_door_timer();
		door_timer = cfg_door_steps;
		door_timed_out = 1'b0;
		add_beep(BEEP_ONE);
	endfunction

	function automatic void flip_alarm();
		if (car_mode != MODE_CODE_ALARM) begin
			car_mode = MODE_CODE_ALARM;
			add_beep(BEEP_ALARM);
		end else begin
			car_mode = MODE_CODE_IDLE;
			car_dir = MOVE_NONE;
			pending_req = '0;
			add_beep(BEEP_ONE);
		end
	endfunction

	// Arrival at a new floor: stop for the target, or for any request picked up on the way.
	function automatic void reach_floor();
		if (car_floor == car_target) begin
			drop_req(car_floor);
			open_door_timer();
			car_mode = MODE_CODE_DOOR;
		end else if (req_at(car_floor)) begin
			drop_req(car_floor);
			open_door_timer();
			car_mode = MODE_CODE_DOOR;
			car_target = pick_target();
		end
	endfunction

	// One time step of the car for one button word; returns the status word it should give.
	function automatic esc_result_t advance_car(logic [7:0] word);
		esc_result_t r;
		int i;
		beep_sum = BEEP_NONE;
		for (i = 0; i < PRESS_W && i < NUM_FLOORS; i++)
			if (word[i] && car_mode != MODE_CODE_ALARM)
				if (!(i + 1 == int'(car_floor) && car_mode == MODE_CODE_DOOR))
					pending_req[i] = 1'b1;
		if ((word & STOP_WORD) != 0)
			flip_alarm();
		if ((word & OPEN_WORD) != 0 && car_mode == MODE_CODE_IDLE) begin
			open_door_timer();
			car_mode = MODE_CODE_MANUAL;
		end
		if ((word & CLOSE_WORD) != 0 &&
				(car_mode == MODE_CODE_DOOR || car_mode == MODE_CODE_MANUAL)) begin
			door_timer = '0;
			car_mode = MODE_CODE_IDLE;
		end

		case (car_mode)
			MODE_CODE_IDLE: begin
				if (pending_req != '0) begin
					if (req_at(car_floor)) begin
						// A request at the floor where the car waits is served in place.
						car_target = car_floor;
						drop_req(car_floor);
						open_door_timer();
						car_mode = MODE_CODE_DOOR;
					end else begin
						car_target = pick_target();
						if (car_target != 3'd0) begin
							if (car_target > car_floor) begin
								car_dir = MOVE_UP;
								car_mode = MODE_CODE_UP;
							end else begin
								car_dir = MOVE_DOWN;
								car_mode = MODE_CODE_DOWN;
							end
							ride_total = ride_total + 32'd1;
						end
					end
				end
			end
			MODE_CODE_UP: begin
				up_steps = up_steps + 16'd1;
				if (up_steps >= cfg_travel_steps) begin
					up_steps = '0;
					if (int'(car_floor) < NUM_FLOORS) begin
						car_floor = car_floor + 3'd1;
						reach_floor();
					end else begin
						flip_alarm();
					end
				end
			end
			MODE_CODE_DOWN: begin
				down_steps = down_steps + 16'd1;
				if (down_steps >= cfg_travel_steps) begin
					down_steps = '0;
					if (car_floor > 3'd1) begin
						car_floor = car_floor - 3'd1;
						reach_floor();
					end else begin
						flip_alarm();
					end
				end
			end
			MODE_CODE_DOOR: begin
				if (door_timed_out) begin
					door_timed_out = 1'b0;
					car_dir = MOVE_NONE;
					car_mode = MODE_CODE_IDLE;
				end
			end
			default: begin
			end
		endcase

		// A zero door time never runs out, so the door waits for a close press.
		if (car_mode == MODE_CODE_DOOR && door_timer > 0) begin
			door_timer = door_timer - 16'd1;
			if (door_timer == 0)
				door_timed_out = 1'b1;
		end

		r.mode = car_mode;
		r.current_floor = car_floor;
		r.target_floor = car_target;
		r.travel_dir = car_dir;
		r.pending_floors = pending_req;
		r.motor_up = (car_mode == MODE_CODE_UP);
		r.motor_down = (car_mode == MODE_CODE_DOWN);
		r.door_open = (car_mode == MODE_CODE_DOOR || car_mode == MODE_CODE_MANUAL);
		r.beeps = beep_sum;
		r.ride_count = ride_total;
		return r;
	endfunction

	function automatic logic [7:0] floor_word(int f);
		return 8'(1 << (f - 1));
	endfunction

	// Mostly short pauses, now and then a long one.
	function automatic int pick_gap();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	// Mostly quiet steps with an occasional button, plus some fully random words.
	function automatic logic [7:0] random_word();
		logic [7:0] w;
		if ($urandom_range(0, 99) < 5)
			return 8'($urandom_range(0, 255));
		w = NO_PRESS;
		if ($urandom_range(0, 5) == 0)
			w = w | (8'($urandom_range(1, 31)) & PRESS_MASK);
		if ($urandom_range(0, 39) == 0)
			w = w | STOP_WORD;
		if ($urandom_range(0, 14) == 0)
			w = w | OPEN_WORD;
		if ($urandom_range(0, 14) == 0)
			w = w | CLOSE_WORD;
		return w;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			bad_fields++;
			if (bad_fields <= MAX_REPORTS)
				$display("%0t ns: %s expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Sends one button word; valid stays high after acceptance unless a gap follows.
	task automatic send_step(input logic [7:0] word);
		int gap;
		gap = (!steady_flow && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		car_status_due.push_back(advance_car(word));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (car_status_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers while the block holds no word.
	task automatic configure(input logic [15:0] travel, input logic [15:0] door);
		int r;
		drain_results();
		for (r = 0; r < 2; r++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (r == 0) ? CFG_TRAVEL_STEPS : CFG_DOOR_OPEN_STEPS;
			cfg_data <= (r == 0) ? travel : door;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_travel_steps = travel;
		cfg_door_steps = door;
	endtask

	// Reset values: door open at floor 1, so a floor 1 press is ignored.
	task automatic test_reset_state();
		send_step(floor_word(1));
		send_step(floor_word(3));
		send_step(CLOSE_WORD);
	endtask

	// Alarm entry while travelling, every button ignored in alarm, exit clearing requests.
	task automatic test_alarm_toggle();
		send_step(STOP_WORD);
		send_step(PRESS_MASK | OPEN_WORD | CLOSE_WORD);
		send_step(STOP_WORD);
		send_step(8'hFF);
		send_step(STOP_WORD);
	endtask

	task automatic test_manual_door();
		send_step(OPEN_WORD);
		send_step(OPEN_WORD);
		send_step(CLOSE_WORD);
	endtask

	// Serve in place, ride up with a stop on the way, then press a floor below while still going up.
	task automatic test_scan_ride();
		configure(16'd1, 16'd2);
		send_step(floor_word(1));
		send_step(floor_word(5));
		send_step(NO_PRESS);
		send_step(NO_PRESS);
		send_step(floor_word(3));
		send_step(NO_PRESS);
		send_step(NO_PRESS);
		send_step(NO_PRESS);
		send_step(NO_PRESS);
		send_step(floor_word(2));
	endtask

	// Zero travel time moves a floor per step; zero door time waits for close.
	task automatic test_zero_config();
		configure(16'd0, 16'd0);
		send_step(floor_word(4));
		send_step(NO_PRESS);
		send_step(NO_PRESS);
		send_step(CLOSE_WORD);
	endtask

	task automatic test_random_traffic();
		int phase;
		int n;
		int k;
		logic [15:0] travel;
		logic [15:0] door;
		for (phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin travel = 16'd1; door = 16'd1; end
				1: begin travel = 16'd0; door = 16'd0; end
				2: begin travel = 16'hFFFF; door = 16'd1; end
				3: begin travel = 16'd1; door = 16'hFFFF; end
				4: begin travel = 16'hFFFF; door = 16'hFFFF; end
				default: begin
					travel = 16'($urandom_range(1, 5));
					door = 16'($urandom_range(1, 8));
				end
			endcase
			configure(travel, door);
			n = (phase >= 2 && phase <= 4) ? 40 : 140;
			for (k = 0; k < n; k++) begin
				if (k % 35 == 0)
					steady_flow = ($urandom_range(0, 3) == 0);
				send_step(random_word());
			end
		end
		steady_flow = 1'b0;
	endtask

	// Result side stalls at random, except during steady stretches.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Every status word taken is checked field by field against the oldest prediction.
	always @(posedge clk) begin : check_status
		esc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (car_status_due.size() == 0) begin
				bad_fields++;
				if (bad_fields <= MAX_REPORTS)
					$display("%0t ns: status word expected none, actual %h", $time, m_tdata);
			end else begin
				want = car_status_due.pop_front();
				report_field("mode", want.mode, m_tdata[2:0]);
				report_field("current_floor", want.current_floor, m_tdata[5:3]);
				report_field("target_floor", want.target_floor, m_tdata[8:6]);
				report_field("travel_dir", want.travel_dir, m_tdata[10:9]);
				report_field("pending_floors", want.pending_floors, m_tdata[15:11]);
				report_field("motor_up", want.motor_up, m_tdata[16]);
				report_field("motor_down", want.motor_down, m_tdata[17]);
				report_field("door_open", want.door_open, m_tdata[18]);
				report_field("beeps", want.beeps, m_tdata[20:19]);
				report_field("ride_count", want.ride_count, m_tdata[52:21]);
				report_field("padding", 32'd0, m_tdata[55:53]);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("elevator_scan_controller_unit: mismatch");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_alarm_toggle();
		test_manual_door();
		test_scan_ride();
		test_zero_config();
		test_random_traffic();
		drain_results();
		if (bad_fields == 0 && car_status_due.size() == 0)
			$display("elevator_scan_controller_unit: match");
		else
			$display("elevator_scan_controller_unit: mismatch");
		$finish;
	end

endmodule
